@@ sv/cpp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cpp_pkg
// Shared types, widths, operation codes and the multiply schedule of the
// camera point projector.
// ----------------------------------------------------------------------------
package cpp_pkg;

	localparam int FOCAL_W  = 12;
	localparam logic [FOCAL_W-1:0] FOCAL_RESET = 12'd400;

	localparam int SCREEN_COLUMNS_DEF = 1000;
	localparam int SCREEN_ROWS_DEF    = 500;

	localparam int COORD_W = 32;   // Q16.16
	localparam int BASIS_W = 16;   // Q2.14
	localparam int DIFF_W  = 33;
	localparam int CROSS_W = 33;
	localparam int OPND_W  = 34;
	localparam int PROD_W  = 68;
	localparam int DET_W   = 52;
	localparam int NUM_W   = 70;
	localparam int DIV_W   = 84;
	localparam int QUOT_W  = 12;
	localparam int HALF_W  = 12;
	localparam int IDX_W   = 13;
	localparam int ROW_W   = 9;
	localparam int COL_W   = 10;
	localparam int EXT_W   = 34;   // working width of move/rotate/load math

	localparam logic signed [EXT_W-1:0] COS_ONE_DEG = 34'sd16382;
	localparam logic signed [EXT_W-1:0] SIN_ONE_DEG = 34'sd286;
	localparam logic signed [EXT_W-1:0] ROUND_Q14   = 34'sd8192;
	localparam logic signed [BASIS_W-1:0] ONE_Q14   = 16'sd16384;

	localparam logic [2:0] OP_PROJECT    = 3'd0;
	localparam logic [2:0] OP_MOVE       = 3'd1;
	localparam logic [2:0] OP_ROTATE     = 3'd2;
	localparam logic [2:0] OP_LOAD_POS   = 3'd3;
	localparam logic [2:0] OP_LOAD_BASIS = 3'd4;

	localparam logic [2:0] KEY_LIMIT = 3'd6;
	localparam logic [1:0] SEL_NONE  = 2'd3;

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;

	// multiply schedule: 18 cross terms, 3 determinant terms, 9 numerator terms
	localparam int STEP_W    = 5;
	localparam logic [STEP_W-1:0] MUL_STEPS = 5'd30;
	localparam int OPND_CNT  = 21;  // 9 basis, 3 offset, 9 cross
	localparam logic [3:0] DEST_DET = 4'd9;
	localparam logic [3:0] DEST_N   = 4'd10;

	typedef enum logic [2:0] {
		K_NONE,
		K_PROJECT,
		K_MOVE,
		K_ROTATE,
		K_LOAD_POS,
		K_LOAD_BASIS
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [2:0]         key;
		logic [1:0]         sel;
	} item_t;

	typedef struct packed {
		logic [4:0] a_sel;
		logic [4:0] b_sel;
		logic [3:0] dest;
		logic       sub;
	} mul_step_t;

	// operand index: 0..8 basis, 9..11 offset, 12..20 cross terms
	// dest: 0..8 cross terms, 9 determinant, 10..12 numerators
	function automatic mul_step_t mul_step(input logic [STEP_W-1:0] s);
		mul_step_t r;
		r = '0;
		unique case (s)
			5'd0:  r = '{5'd4,  5'd8,  4'd0,  1'b0};
			5'd1:  r = '{5'd5,  5'd7,  4'd0,  1'b1};
			5'd2:  r = '{5'd5,  5'd6,  4'd1,  1'b0};
			5'd3:  r = '{5'd3,  5'd8,  4'd1,  1'b1};
			5'd4:  r = '{5'd3,  5'd7,  4'd2,  1'b0};
			5'd5:  r = '{5'd4,  5'd6,  4'd2,  1'b1};
			5'd6:  r = '{5'd7,  5'd2,  4'd3,  1'b0};
			5'd7:  r = '{5'd8,  5'd1,  4'd3,  1'b1};
			5'd8:  r = '{5'd8,  5'd0,  4'd4,  1'b0};
			5'd9:  r = '{5'd6,  5'd2,  4'd4,  1'b1};
			5'd10: r = '{5'd6,  5'd1,  4'd5,  1'b0};
			5'd11: r = '{5'd7,  5'd0,  4'd5,  1'b1};
			5'd12: r = '{5'd1,  5'd5,  4'd6,  1'b0};
			5'd13: r = '{5'd2,  5'd4,  4'd6,  1'b1};
			5'd14: r = '{5'd2,  5'd3,  4'd7,  1'b0};
			5'd15: r = '{5'd0,  5'd5,  4'd7,  1'b1};
			5'd16: r = '{5'd0,  5'd4,  4'd8,  1'b0};
			5'd17: r = '{5'd1,  5'd3,  4'd8,  1'b1};
			5'd18: r = '{5'd0,  5'd12, 4'd9,  1'b0};
			5'd19: r = '{5'd1,  5'd13, 4'd9,  1'b0};
			5'd20: r = '{5'd2,  5'd14, 4'd9,  1'b0};
			5'd21: r = '{5'd9,  5'd12, 4'd10, 1'b0};
			5'd22: r = '{5'd10, 5'd13, 4'd10, 1'b0};
			5'd23: r = '{5'd11, 5'd14, 4'd10, 1'b0};
			5'd24: r = '{5'd9,  5'd15, 4'd11, 1'b0};
			5'd25: r = '{5'd10, 5'd16, 4'd11, 1'b0};
			5'd26: r = '{5'd11, 5'd17, 4'd11, 1'b0};
			5'd27: r = '{5'd9,  5'd18, 4'd12, 1'b0};
			5'd28: r = '{5'd10, 5'd19, 4'd12, 1'b0};
			5'd29: r = '{5'd11, 5'd20, 4'd12, 1'b0};
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [BASIS_W-1:0] sat16(input logic signed [EXT_W-1:0] v);
		logic signed [BASIS_W-1:0] r;
		if (v > 34'sd32767) r = 16'sh7fff;
		else if (v < -34'sd32768) r = 16'sh8000;
		else r = v[BASIS_W-1:0];
		return r;
	endfunction

	function automatic logic signed [COORD_W-1:0] sat32(input logic signed [EXT_W-1:0] v);
		logic signed [COORD_W-1:0] r;
		if (v > 34'sd2147483647) r = 32'sh7fffffff;
		else if (v < -34'sd2147483648) r = 32'sh80000000;
		else r = v[COORD_W-1:0];
		return r;
	endfunction

endpackage
`default_nettype wire

@@ sv/cpp_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cpp_front
// Accepts items, classifies them by kind and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module cpp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  logic [2:0]          operation,
	input  logic signed [31:0]  point_x,
	input  logic signed [31:0]  point_y,
	input  logic signed [31:0]  point_z,
	input  logic [2:0]          key_code,
	input  logic [1:0]          basis_select,
	output logic                q_valid,
	output cpp_pkg::item_t      q_item,
	input  logic                q_pop
);
	import cpp_pkg::*;

	localparam int CNT_W = Q_PTR_W + 1;

	item_t              cls;
	item_t              mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_q;
	logic [Q_PTR_W-1:0] rd_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               push;

	always_comb begin
		cls.x   = point_x;
		cls.y   = point_y;
		cls.z   = point_z;
		cls.key = key_code;
		cls.sel = basis_select;
		unique case (operation)
			OP_PROJECT:    cls.kind = K_PROJECT;
			OP_MOVE:       cls.kind = (key_code < KEY_LIMIT) ? K_MOVE : K_NONE;
			OP_ROTATE:     cls.kind = (key_code < KEY_LIMIT) ? K_ROTATE : K_NONE;
			OP_LOAD_POS:   cls.kind = K_LOAD_POS;
			OP_LOAD_BASIS: cls.kind = (basis_select != SEL_NONE) ? K_LOAD_BASIS : K_NONE;
			default:       cls.kind = K_NONE;
		endcase
	end

	assign item_stall = (cnt_q == CNT_W'(Q_DEPTH));
	assign push       = item_valid && !item_stall;
	assign q_valid    = (cnt_q != '0);
	assign q_item     = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (q_pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(q_pop);
		end
	end

endmodule
`default_nettype wire

@@ sv/cpp_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cpp_back
// Camera state, one shared signed multiplier for the Cramer terms, the
// serial quotient for each screen axis, and the result register.
// ----------------------------------------------------------------------------
module cpp_back #(
	parameter int SCREEN_COLUMNS = cpp_pkg::SCREEN_COLUMNS_DEF,
	parameter int SCREEN_ROWS    = cpp_pkg::SCREEN_ROWS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [cpp_pkg::FOCAL_W-1:0]   focal,
	input  logic                          q_valid,
	input  cpp_pkg::item_t                q_item,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          visible,
	output logic [cpp_pkg::ROW_W-1:0]     pixel_row,
	output logic [cpp_pkg::COL_W-1:0]     pixel_column,
	output logic                          singular
);
	import cpp_pkg::*;

	localparam logic [HALF_W-1:0] COL_HALF = HALF_W'(SCREEN_COLUMNS / 2);
	localparam logic [HALF_W-1:0] ROW_HALF = HALF_W'(SCREEN_ROWS / 2);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_MUL    = 8'b0000_0010,
		S_CHECK  = 8'b0000_0100,
		S_PL_MUL = 8'b0000_1000,
		S_PL_CMP = 8'b0001_0000,
		S_PL_DIV = 8'b0010_0000,
		S_PL_FIN = 8'b0100_0000,
		S_RES    = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic signed [COORD_W-1:0] pos_q   [3];
	logic signed [BASIS_W-1:0] basis_q [9];
	logic signed [DIFF_W-1:0]  p_q     [3];
	logic signed [CROSS_W-1:0] cross_q [9];
	logic signed [DET_W-1:0]   det_q;
	logic signed [NUM_W-1:0]   n_q     [3];
	logic signed [PROD_W-1:0]  prod_q;
	logic [3:0]                tag_dest_q;
	logic                      tag_sub_q;
	logic                      acc_en_q;
	logic [STEP_W-1:0]         cnt_q;
	logic                      axis_q;
	logic                      neg_q;
	logic [DIV_W-1:0]          num_q;
	logic [DIV_W-1:0]          lim_q;
	logic [DIV_W-1:0]          dsh_q;
	logic [QUOT_W-1:0]         quot_q;
	logic [3:0]                k_q;
	logic [COL_W-1:0]          col_q;
	logic [ROW_W-1:0]          row_q;
	logic                      res_vis_q;
	logic                      res_sing_q;
	logic                      out_valid_q;
	logic                      vis_q;
	logic [ROW_W-1:0]          prow_q;
	logic [COL_W-1:0]          pcol_q;
	logic                      sing_q;

	logic                      out_free;
	logic                      direct;
	logic                      res_load;
	mul_step_t                 step;
	logic signed [OPND_W-1:0]  opnd [OPND_CNT];
	logic signed [OPND_W-1:0]  opa;
	logic signed [OPND_W-1:0]  opb;
	logic signed [NUM_W-1:0]   acc_old;
	logic signed [NUM_W-1:0]   acc_new;
	logic signed [NUM_W-1:0]   nfix [3];
	logic signed [NUM_W-1:0]   nsel;
	logic [NUM_W-1:0]          mag;
	logic [HALF_W-1:0]         half;
	logic [IDX_W-1:0]          idx;
	logic signed [COORD_W-1:0] pt   [3];
	logic signed [COORD_W-1:0] mv   [3];
	logic signed [BASIS_W-1:0] lb   [3];
	logic signed [BASIS_W-1:0] ra   [3];
	logic signed [BASIS_W-1:0] rb   [3];
	logic [1:0]                ia;
	logic [1:0]                ib;

	assign out_free = !out_valid_q || !out_stall;
	assign direct   = (q_item.kind != K_PROJECT);
	assign q_pop    = (state_q == S_IDLE) && q_valid && (!direct || out_free);
	// a new result enters the output register this cycle
	assign res_load = ((state_q == S_IDLE) && q_pop && direct) ||
		((state_q == S_RES) && out_free);

	assign out_valid    = out_valid_q;
	assign visible      = vis_q;
	assign pixel_row    = prow_q;
	assign pixel_column = pcol_q;
	assign singular     = sing_q;

	// operand bank for the shared multiplier
	always_comb begin
		for (int i = 0; i < 9; i++) begin
			opnd[i]      = OPND_W'(basis_q[i]);
			opnd[12 + i] = OPND_W'(cross_q[i]);
		end
		for (int i = 0; i < 3; i++) begin
			opnd[9 + i] = OPND_W'(p_q[i]);
		end
		step = mul_step(cnt_q);
		opa  = opnd[step.a_sel];
		opb  = opnd[step.b_sel];
	end

	always_comb begin
		if (tag_dest_q < DEST_DET) acc_old = NUM_W'(cross_q[tag_dest_q]);
		else if (tag_dest_q == DEST_DET) acc_old = NUM_W'(det_q);
		else acc_old = n_q[2'(tag_dest_q - DEST_N)];
		acc_new = tag_sub_q ? acc_old - NUM_W'(prod_q) : acc_old + NUM_W'(prod_q);
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nfix[i] = det_q[DET_W-1] ? -n_q[i] : n_q[i];
		end
		nsel = axis_q ? n_q[2] : n_q[1];
		mag  = nsel[NUM_W-1] ? NUM_W'(-nsel) : NUM_W'(nsel);
		half = axis_q ? ROW_HALF : COL_HALF;
		if (neg_q) idx = IDX_W'(half) - 1'b1 + IDX_W'(quot_q);
		else idx = IDX_W'(half) - 1'b1 - IDX_W'(quot_q);
	end

	// combinational camera updates
	always_comb begin
		logic signed [EXT_W-1:0] d;
		logic signed [EXT_W-1:0] a;
		logic signed [EXT_W-1:0] b;
		logic signed [EXT_W-1:0] s;
		pt[0] = q_item.x;
		pt[1] = q_item.y;
		pt[2] = q_item.z;
		case (q_item.key[2:1])
			2'd0:    begin ia = 2'd0; ib = 2'd1; end
			2'd1:    begin ia = 2'd0; ib = 2'd2; end
			default: begin ia = 2'd1; ib = 2'd2; end
		endcase
		s = q_item.key[0] ? -SIN_ONE_DEG : SIN_ONE_DEG;
		for (int c = 0; c < 3; c++) begin
			d = EXT_W'(basis_q[4'(q_item.key[2:1]) * 4'd3 + 4'(c)]) <<< 2;
			mv[c] = sat32(EXT_W'(pos_q[c]) + (q_item.key[0] ? -d : d));
			lb[c] = sat16((EXT_W'(pt[c]) + 34'sd2) >>> 2);
			a = EXT_W'(basis_q[4'(ia) * 4'd3 + 4'(c)]);
			b = EXT_W'(basis_q[4'(ib) * 4'd3 + 4'(c)]);
			ra[c] = sat16((a * COS_ONE_DEG + b * s + ROUND_Q14) >>> 14);
			rb[c] = sat16((b * COS_ONE_DEG - a * s + ROUND_Q14) >>> 14);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_MUL && cnt_q != MUL_STEPS) begin
			prod_q     <= opa * opb;
			tag_dest_q <= step.dest;
			tag_sub_q  <= step.sub;
		end
		if (acc_en_q) begin
			if (tag_dest_q < DEST_DET) cross_q[tag_dest_q] <= CROSS_W'(acc_new);
			else if (tag_dest_q == DEST_DET) det_q <= DET_W'(acc_new);
			else n_q[2'(tag_dest_q - DEST_N)] <= acc_new;
		end
		if (q_pop && !direct) begin
			for (int c = 0; c < 3; c++) begin
				p_q[c]     <= DIFF_W'(pt[c]) - DIFF_W'(pos_q[c]);
				n_q[c]     <= '0;
			end
			for (int c = 0; c < 9; c++) cross_q[c] <= '0;
			det_q <= '0;
		end
		if (state_q == S_CHECK) begin
			for (int c = 0; c < 3; c++) n_q[c] <= nfix[c];
		end
		unique case (state_q)
			S_PL_MUL: begin
				neg_q <= nsel[NUM_W-1];
				num_q <= DIV_W'(mag) * DIV_W'(focal);
				lim_q <= DIV_W'(n_q[0]) * DIV_W'(half);
			end
			S_PL_CMP: begin
				dsh_q  <= DIV_W'(n_q[0]) << (QUOT_W - 1);
				k_q    <= 4'(QUOT_W - 1);
				quot_q <= '0;
			end
			S_PL_DIV: begin
				if (dsh_q <= num_q) begin
					num_q         <= num_q - dsh_q;
					quot_q[k_q]   <= 1'b1;
				end
				dsh_q <= dsh_q >> 1;
				k_q   <= k_q - 1'b1;
			end
			S_PL_FIN: begin
				if (!axis_q) col_q <= idx[COL_W-1:0];
				else row_q <= idx[ROW_W-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			acc_en_q    <= 1'b0;
			axis_q      <= 1'b0;
			res_vis_q   <= 1'b0;
			res_sing_q  <= 1'b0;
			out_valid_q <= 1'b0;
			vis_q       <= 1'b0;
			prow_q      <= '0;
			pcol_q      <= '0;
			sing_q      <= 1'b0;
			for (int c = 0; c < 3; c++) pos_q[c] <= '0;
			for (int c = 0; c < 9; c++) basis_q[c] <= (c % 4 == 0) ? ONE_Q14 : '0;
		end else begin
			acc_en_q <= (state_q == S_MUL) && (cnt_q != MUL_STEPS);
			if (out_valid_q && !out_stall && !res_load) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_pop && direct) begin
						out_valid_q <= 1'b1;
						vis_q       <= 1'b0;
						prow_q      <= '0;
						pcol_q      <= '0;
						sing_q      <= 1'b0;
						case (q_item.kind)
							K_MOVE:     for (int c = 0; c < 3; c++) pos_q[c] <= mv[c];
							K_LOAD_POS: for (int c = 0; c < 3; c++) pos_q[c] <= pt[c];
							K_LOAD_BASIS:
								for (int c = 0; c < 3; c++)
									basis_q[4'(q_item.sel) * 4'd3 + 4'(c)] <= lb[c];
							K_ROTATE: begin
								for (int c = 0; c < 3; c++) begin
									basis_q[4'(ia) * 4'd3 + 4'(c)] <= ra[c];
									basis_q[4'(ib) * 4'd3 + 4'(c)] <= rb[c];
								end
							end
							default: ;
						endcase
					end else if (q_pop) begin
						cnt_q      <= '0;
						res_vis_q  <= 1'b0;
						res_sing_q <= 1'b0;
						axis_q     <= 1'b0;
						state_q    <= S_MUL;
					end
				end
				S_MUL: begin
					if (cnt_q == MUL_STEPS) state_q <= S_CHECK;
					else cnt_q <= cnt_q + 1'b1;
				end
				S_CHECK: begin
					if (det_q == '0) begin
						res_sing_q <= 1'b1;
						state_q    <= S_RES;
					end else if (nfix[0][NUM_W-1] || nfix[0] == '0) begin
						state_q <= S_RES;
					end else begin
						state_q <= S_PL_MUL;
					end
				end
				S_PL_MUL: state_q <= S_PL_CMP;
				S_PL_CMP: state_q <= (num_q > lim_q) ? S_RES : S_PL_DIV;
				S_PL_DIV: if (k_q == '0) state_q <= S_PL_FIN;
				S_PL_FIN: begin
					if (!neg_q && quot_q >= half) begin
						state_q <= S_RES;
					end else if (!axis_q) begin
						axis_q  <= 1'b1;
						state_q <= S_PL_MUL;
					end else begin
						res_vis_q <= 1'b1;
						state_q   <= S_RES;
					end
				end
				S_RES: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						vis_q       <= res_vis_q;
						prow_q      <= res_vis_q ? row_q : '0;
						pcol_q      <= res_vis_q ? col_q : '0;
						sing_q      <= res_sing_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ sv/camera_point_projector.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// camera_point_projector
// Pinhole camera: keeps a camera position and basis, projects points to
// screen pixels.
// ----------------------------------------------------------------------------
// Items enter a two-entry queue and are carried out one at a time. Move,
// rotate and load items are applied as they leave the queue and return an
// all-zero result. A project item runs 30 products through one shared signed
// multiplier for the cross terms, determinant and Cramer numerators, then per
// screen axis a scale step and a 12-step restoring quotient, one bit a cycle.
// The result register lets a queued project item start while a result waits.
module camera_point_projector #(
	parameter int SCREEN_COLUMNS = cpp_pkg::SCREEN_COLUMNS_DEF,
	parameter int SCREEN_ROWS    = cpp_pkg::SCREEN_ROWS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [2:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	input  logic                      item_valid,
	output logic                      item_stall,
	input  logic [2:0]                operation,
	input  logic signed [31:0]        point_x,
	input  logic signed [31:0]        point_y,
	input  logic signed [31:0]        point_z,
	input  logic [2:0]                key_code,
	input  logic [1:0]                basis_select,
	output logic                      result_valid,
	input  logic                      result_stall,
	output logic                      visible,
	output logic [cpp_pkg::ROW_W-1:0] pixel_row,
	output logic [cpp_pkg::COL_W-1:0] pixel_column,
	output logic                      singular
);
	import cpp_pkg::*;

	logic [FOCAL_W-1:0] focal_q;
	logic               cfg_wr;
	logic               q_valid;
	item_t              q_item;
	logic               q_pop;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
	assign prdata = paddr[2] ? '0 : 32'(focal_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_q <= FOCAL_RESET;
		end else if (cfg_wr) begin
			focal_q <= pwdata[FOCAL_W-1:0];
		end
	end

	cpp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.operation    (operation),
		.point_x      (point_x),
		.point_y      (point_y),
		.point_z      (point_z),
		.key_code     (key_code),
		.basis_select (basis_select),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop)
	);

	cpp_back #(
		.SCREEN_COLUMNS (SCREEN_COLUMNS),
		.SCREEN_ROWS    (SCREEN_ROWS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.focal        (focal_q),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.out_valid    (result_valid),
		.out_stall    (result_stall),
		.visible      (visible),
		.pixel_row    (pixel_row),
		.pixel_column (pixel_column),
		.singular     (singular)
	);

	a_sing_hidden: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(singular && visible))
		else $error("singular result marked visible");

	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !visible) |-> (pixel_row == '0 && pixel_column == '0))
		else $error("hidden result carries pixel coordinates");

	a_focal_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> focal_q == $past(pwdata[FOCAL_W-1:0]))
		else $error("focal distance write lost");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

endmodule
`default_nettype wire
